// File: rtl/quoted_argument_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_assert
// Assertion macros for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QAT_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qat: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QAT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qat: next-cycle check failed");

`endif

// File: rtl/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants of the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 9;

  // Largest argument limit; a larger register value acts as this one.
  localparam logic [COUNT_W-1:0] LIMIT_CAP = 9'd256;

  // Default depth of the queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_ARG     = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_OCT1    = 3'd3,
    MODE_OCT2    = 3'd4,
    MODE_HEX0    = 3'd5,
    MODE_HEX1    = 3'd6,
    MODE_WAIT    = 3'd7
  } mode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] arg_count;
    logic               last;
  } result_t;

  // All results caused by one input byte: one, or two when pair is set.
  typedef struct packed {
    logic    pair;
    result_t res0;
    result_t res1;
  } entry_t;

  // Parser status seen by the top level.
  typedef struct packed {
    mode_t              mode;
    logic [COUNT_W-1:0] count;
  } front_status_t;

endpackage

// File: rtl/qat_front.sv
// ----------------------------------------------------------------------------
// qat_front
// Byte parser: accepts one text byte per cycle unless the queue is full,
// updates the parse state and pushes that byte's results as one entry.
// ----------------------------------------------------------------------------
module qat_front
  import qat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [COUNT_W-1:0] cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_text_byte,
  input  logic               q_full,
  output logic               push,
  output entry_t             push_entry,
  output front_status_t      status
);

  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  mode_t              mode_r, mode_nxt;
  logic               quoted_r, quoted_nxt;
  logic [BYTE_W-1:0]  esc_r, esc_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] max_r;

  logic [BYTE_W-1:0]  c;
  logic               accept;
  logic               is_print, is_space;
  logic [4:0]         hex;
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] count_inc;
  logic [BYTE_W-1:0]  esc_done_val;

  logic               arg_step, quoted_eff;
  logic               end_req, done_req, err_req, byte_req, esc_done;
  logic [BYTE_W-1:0]  byte_val;
  logic               emit;
  entry_t             entry;

  assign c         = in_text_byte;
  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;
  assign is_print  = (c >= 8'h20) && (c <= 8'h7E);
  assign is_space  = (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  assign hex       = hex_digit(c);
  assign limit     = (max_r > LIMIT_CAP) ? LIMIT_CAP : max_r;
  assign count_inc = count_r + 9'd1;

  // Value completed by the final octal or hex digit.
  assign esc_done_val = (mode_r == MODE_OCT2) ? {esc_r[4:0], c[2:0]}
                                              : {esc_r[7:4], hex[3:0]};

  // Next parse state and the results of the current byte.
  always_comb begin
    mode_nxt   = mode_r;
    quoted_nxt = quoted_r;
    esc_nxt    = esc_r;
    count_nxt  = count_r;
    arg_step   = 1'b0;
    quoted_eff = quoted_r;
    end_req    = 1'b0;
    done_req   = 1'b0;
    err_req    = 1'b0;
    byte_req   = 1'b0;
    esc_done   = 1'b0;
    byte_val   = c;
    emit       = 1'b0;
    entry      = '0;
    entry.res0.kind = KIND_BYTE;
    entry.res1.kind = KIND_DONE;

    case (mode_r)
      MODE_BETWEEN: begin
        if (c == 8'h00) begin
          emit = 1'b1;
          entry.res0.kind      = KIND_DONE;
          entry.res0.arg_count = count_r;
          mode_nxt   = MODE_BETWEEN;
          quoted_nxt = 1'b0;
          esc_nxt    = '0;
          count_nxt  = '0;
        end else if (!is_space) begin
          mode_nxt   = MODE_ARG;
          quoted_nxt = 1'b0;
          quoted_eff = 1'b0;
          arg_step   = 1'b1;
        end
      end
      MODE_ARG: begin
        arg_step = 1'b1;
      end
      MODE_ESC: begin
        mode_nxt = MODE_ARG;
        case (c)
          8'h22:   begin byte_req = 1'b1; byte_val = 8'h22; end
          8'h5C:   begin byte_req = 1'b1; byte_val = 8'h5C; end
          8'h66:   begin byte_req = 1'b1; byte_val = 8'h0C; end
          8'h6E:   begin byte_req = 1'b1; byte_val = 8'h0A; end
          8'h72:   begin byte_req = 1'b1; byte_val = 8'h0D; end
          8'h74:   begin byte_req = 1'b1; byte_val = 8'h09; end
          8'h61:   begin byte_req = 1'b1; byte_val = 8'h07; end
          8'h62:   begin byte_req = 1'b1; byte_val = 8'h08; end
          8'h76:   begin byte_req = 1'b1; byte_val = 8'h0B; end
          8'h78:   mode_nxt = MODE_HEX0;
          default: begin
            if (c >= 8'h30 && c <= 8'h33) begin
              esc_nxt  = {6'd0, c[1:0]};
              mode_nxt = MODE_OCT1;
            end else begin
              err_req = 1'b1;
            end
          end
        endcase
      end
      MODE_OCT1, MODE_OCT2: begin
        if (c >= 8'h30 && c <= 8'h37) begin
          if (mode_r == MODE_OCT1) begin
            esc_nxt  = {esc_r[4:0], c[2:0]};
            mode_nxt = MODE_OCT2;
          end else begin
            esc_nxt  = esc_done_val;
            esc_done = 1'b1;
          end
        end else begin
          err_req = 1'b1;
        end
      end
      MODE_HEX0, MODE_HEX1: begin
        if (!hex[4]) begin
          err_req = 1'b1;
        end else if (mode_r == MODE_HEX0) begin
          esc_nxt  = {hex[3:0], 4'd0};
          mode_nxt = MODE_HEX1;
        end else begin
          esc_nxt  = esc_done_val;
          esc_done = 1'b1;
        end
      end
      default: begin
        // Waiting after an error: the zero byte starts a fresh text.
        if (c == 8'h00) begin
          mode_nxt   = MODE_BETWEEN;
          quoted_nxt = 1'b0;
          esc_nxt    = '0;
          count_nxt  = '0;
        end
      end
    endcase

    // A byte belonging to an argument.
    if (arg_step) begin
      if (quoted_eff) begin
        if (!is_print) begin
          err_req = 1'b1;
        end else if (c == CH_QUOTE) begin
          quoted_nxt = 1'b0;
        end else if (c == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          byte_req = 1'b1;
        end
      end else begin
        if (c == 8'h00) begin
          end_req  = 1'b1;
          done_req = 1'b1;
        end else if (!is_print) begin
          err_req = 1'b1;
        end else if (c == CH_SPACE) begin
          end_req = 1'b1;
        end else if (c == CH_QUOTE) begin
          quoted_nxt = 1'b1;
        end else begin
          byte_req = 1'b1;
        end
      end
    end

    // A finished numeric escape: zero ends the argument, else a byte.
    if (esc_done) begin
      if (esc_done_val == 8'h00) begin
        end_req = 1'b1;
      end else begin
        byte_req = 1'b1;
        byte_val = esc_done_val;
        mode_nxt = MODE_ARG;
      end
    end

    // End of an argument, checked against the limit.
    if (end_req) begin
      if (count_r >= limit) begin
        err_req = 1'b1;
      end else begin
        emit = 1'b1;
        entry.res0.kind      = KIND_END;
        entry.res0.arg_count = count_inc;
        count_nxt  = count_inc;
        mode_nxt   = MODE_BETWEEN;
        quoted_nxt = 1'b0;
        if (done_req) begin
          entry.pair           = 1'b1;
          entry.res1.kind      = KIND_DONE;
          entry.res1.arg_count = count_inc;
          esc_nxt   = '0;
          count_nxt = '0;
        end
      end
    end

    // Errors: a zero byte restarts at once, anything else waits for one.
    if (err_req) begin
      emit = 1'b1;
      entry.res0.kind      = KIND_ERR;
      entry.res0.arg_count = count_r;
      if (c == 8'h00) begin
        mode_nxt   = MODE_BETWEEN;
        quoted_nxt = 1'b0;
        esc_nxt    = '0;
        count_nxt  = '0;
      end else begin
        mode_nxt = MODE_WAIT;
      end
    end

    // Decoded data byte.
    if (byte_req) begin
      emit = 1'b1;
      entry.res0.kind      = KIND_BYTE;
      entry.res0.value     = byte_val;
      entry.res0.arg_count = count_r;
    end

    entry.res0.last = ~entry.pair;
    entry.res1.last = 1'b1;
  end

  assign push          = accept & emit;
  assign push_entry    = entry;
  assign status.mode   = mode_r;
  assign status.count  = count_r;

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BETWEEN;
      quoted_r <= 1'b0;
      esc_r    <= '0;
      count_r  <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      quoted_r <= quoted_nxt;
      esc_r    <= esc_nxt;
      count_r  <= count_nxt;
    end
  end

  // Argument limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= LIMIT_CAP;
    end else if (cfg_write_en) begin
      max_r <= cfg_write_data;
    end
  end

endmodule

// File: rtl/qat_queue.sv
// ----------------------------------------------------------------------------
// qat_queue
// Short FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module qat_queue
  import qat_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   q_valid,
  output logic   q_full,
  output entry_t q_head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_FULL);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = push & ~q_full;
  assign do_pop  = pop & q_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/qat_back.sv
// ----------------------------------------------------------------------------
// qat_back
// Output stage: takes entries from the queue and presents their results one
// per cycle on the result channel while out_stall is low.
// ----------------------------------------------------------------------------
module qat_back
  import qat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  entry_t             q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [BYTE_W-1:0]  out_value,
  output logic [COUNT_W-1:0] out_arg_count,
  output logic               out_last
);

  entry_t  hold_r;
  logic    hold_valid_r;
  logic    idx_r;
  result_t cur;
  logic    advance, entry_done;

  assign cur        = idx_r ? hold_r.res1 : hold_r.res0;
  assign advance    = hold_valid_r & ~out_stall;
  assign entry_done = advance & (idx_r | ~hold_r.pair);
  assign pop        = q_valid & (~hold_valid_r | entry_done);

  assign out_valid     = hold_valid_r;
  assign out_kind      = cur.kind;
  assign out_value     = cur.value;
  assign out_arg_count = cur.arg_count;
  assign out_last      = cur.last;

  // Held entry payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      hold_r <= q_head;
    end
  end

  // Held entry control: valid flag and which of its results is shown.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= 1'b0;
    end else if (pop) begin
      hold_valid_r <= 1'b1;
      idx_r        <= 1'b0;
    end else if (entry_done) begin
      hold_valid_r <= 1'b0;
      idx_r        <= 1'b0;
    end else if (advance) begin
      idx_r <= 1'b1;
    end
  end

endmodule

// File: rtl/quoted_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a zero-terminated text into quoted, escape-decoded arguments.
// ----------------------------------------------------------------------------
// Usage:
// - The input channel (in_valid, in_stall, in_text_byte) takes one text byte
//   per transfer; a zero byte ends the text.
// - The result channel (out_valid, out_stall, out_kind, out_value,
//   out_arg_count, out_last) gives decoded bytes, end-of-argument markers,
//   a text-done result with the count, or an error; out_last marks the
//   final result of one input byte.
// - cfg_write_en with cfg_write_data sets the argument limit (reset 256).
// - Results: a byte's results pass through the queue and then the output
//   stage's hold register before they are presented.
// - Throughput: one byte per cycle while in_stall is low; a byte with two
//   results (a zero byte that ends an argument) holds the output stage for both.
// - The parser and the output stage are decoupled by a queue of
//   QUEUE_DEPTH entries; in_stall rises only when that queue is full.
// - A stalled receiver holds the current result steady; bytes keep being
//   taken until the queue fills.
// - Reset clears the parse state, empties the queue and sets the limit to 256.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer
  import qat_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [COUNT_W-1:0] cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_text_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [BYTE_W-1:0]  out_value,
  output logic [COUNT_W-1:0] out_arg_count,
  output logic               out_last
);

  `include "quoted_argument_tokenizer_assert.svh"

  logic          push, pop, q_valid, q_full;
  entry_t        push_entry, q_head;
  front_status_t status;
  logic          zero_taken, fresh_state;

  // Parser.
  qat_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry),
    .status         (status)
  );

  // Queue between parser and output stage.
  qat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .q_head     (q_head)
  );

  // Output stage.
  qat_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_arg_count (out_arg_count),
    .out_last      (out_last)
  );

  // Terms used by the checks below.
  assign zero_taken  = in_valid & ~in_stall & (in_text_byte == 8'h00);
  assign fresh_state = (status.mode == MODE_BETWEEN) && (status.count == '0);

  // A zero byte always leaves the parser at the start of a fresh text.
  `QAT_ASSERT_NEXT(a_zero_restarts, zero_taken, fresh_state)
  // After a push the queue is not empty the next cycle.
  `QAT_ASSERT_NEXT(a_push_visible, push, q_valid)
  // Only decoded bytes carry a nonzero value.
  `QAT_ASSERT_SAME(a_value_zero, out_valid && (out_kind != KIND_BYTE), out_value == 8'h00)

endmodule
